/* sv/nmpc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package nmpc_pkg;

  // Default image size limit in pixels.
  localparam int unsigned MAX_PIXELS_DEF = 16384;

  // Register reset values.
  localparam logic [7:0] BACKWARD_LIMIT_RST = 8'd90;
  localparam logic [7:0] MIN_AVG_BLUE_RST   = 8'd230;
  localparam logic [7:0] HUE_TOL_RST        = 8'd60;

  localparam logic [8:0] HUE_CENTER  = 9'd128;
  localparam int unsigned PERCENT_DIV = 100;

  // Configuration register indexes.
  localparam logic [1:0] REG_BACKWARD_LIMIT = 2'd0;
  localparam logic [1:0] REG_MIN_AVG_BLUE   = 2'd1;
  localparam logic [1:0] REG_HUE_TOL        = 2'd2;

  // Verdict codes.
  localparam logic [1:0] VERDICT_HUE      = 2'd0;
  localparam logic [1:0] VERDICT_BACKWARD = 2'd1;
  localparam logic [1:0] VERDICT_NORMAL   = 2'd2;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } state_e;

  // Control strobes of the sequencer.
  typedef struct packed {
    logic load_rem;
    logic div_step;
    logic div_last;
    logic finish;
  } ctrl_t;

endpackage

`default_nettype wire

/* sv/normal_map_pixel_classifier_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Normal map pixel classifier.
// Pixels enter on the s_axis channel (tdata: red, green, blue from bit 0 up;
// tlast marks the final pixel of an image). While the block accumulates it
// takes one word per cycle: sums, pixel count and backward count update in
// the cycle the word is accepted. Pixels past MAX_PIXELS are dropped, but
// their tlast still ends the image.
// After the last pixel the block drops s_axis_tready and a shared 8-bit
// restoring divider forms the three averages one quotient bit per cycle,
// one channel after the other, each channel in a load step (ST_LOAD) and
// its division steps (ST_DIV); a final step (ST_FIN) forms the verdict and
// loads the result word into the output register that drives m_axis. The
// next image can start right after that final step.
// The result sits in an output register. If the receiver stalls, the block
// keeps accepting pixels of the next image and only holds in its final
// step until that register is free.
// The cfg channel is always ready; index 0 is the backward blue limit,
// 1 the minimum average blue, 2 the hue tolerance. Write it only while idle.
// Reset clears the accumulators and the output valid and restores the
// register defaults 90, 230 and 60.

module normal_map_pixel_classifier_unit #(
  parameter int unsigned MAX_PIXELS = nmpc_pkg::MAX_PIXELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  wire logic        s_axis_tlast,   // last_pixel
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // average_red, average_green, average_blue
  output logic [1:0]       m_axis_tuser,   // verdict
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int SW = $clog2(255 * MAX_PIXELS + 1);
  localparam int BW = CW + 7;

  nmpc_pkg::state_e state_q, state_d;
  nmpc_pkg::ctrl_t  ctrl;

  logic [7:0]    bwd_limit_q, min_blue_q, hue_tol_q;
  logic [SW-1:0] red_sum_q, green_sum_q, blue_sum_q;
  logic [CW-1:0] cnt_q, bwd_q;
  logic [SW-1:0] rem_q;
  logic [7:0]    quo_q;
  logic [2:0]    bit_q;
  logic [1:0]    ch_q;
  logic [7:0]    avg_q [3];
  logic          m_valid_q;
  logic [23:0]   m_data_q;
  logic [1:0]    m_user_q;

  logic          pix_acc, pix_take, out_free;
  logic [SW-1:0] sum_sel;
  logic [SW:0]   dvs, trial;
  logic          ge;
  logic [7:0]    quo_next;
  logic [1:0]    verdict;
  logic          hue_bad, many_bwd;

  function automatic logic outside_hue(input logic [7:0] a, input logic [7:0] t);
    logic lo_bad, hi_bad;
    lo_bad = ({1'b0, a} + {1'b0, t}) < nmpc_pkg::HUE_CENTER;
    hi_bad = {1'b0, a} > ({1'b0, t} + nmpc_pkg::HUE_CENTER);
    return lo_bad || hi_bad;
  endfunction

  assign s_axis_tready = (state_q == nmpc_pkg::ST_ACC);
  assign cfg_ready_o   = 1'b1;
  assign pix_acc  = s_axis_tvalid && s_axis_tready;
  assign pix_take = pix_acc && (cnt_q < CW'(MAX_PIXELS));
  assign out_free = !m_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nmpc_pkg::ST_ACC:  if (pix_acc && s_axis_tlast) state_d = nmpc_pkg::ST_LOAD;
      nmpc_pkg::ST_LOAD: state_d = nmpc_pkg::ST_DIV;
      nmpc_pkg::ST_DIV: begin
        if (bit_q == 3'd0) begin
          state_d = (ch_q == 2'd2) ? nmpc_pkg::ST_FIN : nmpc_pkg::ST_LOAD;
        end
      end
      nmpc_pkg::ST_FIN:  if (out_free) state_d = nmpc_pkg::ST_ACC;
      default:           state_d = nmpc_pkg::ST_ACC;
    endcase
  end

  // Sequencer strobes.
  always_comb begin
    ctrl = '0;
    unique case (state_q)
      nmpc_pkg::ST_ACC:  ctrl = '0;
      nmpc_pkg::ST_LOAD: ctrl.load_rem = 1'b1;
      nmpc_pkg::ST_DIV: begin
        ctrl.div_step = 1'b1;
        ctrl.div_last = (bit_q == 3'd0);
      end
      nmpc_pkg::ST_FIN:  ctrl.finish = out_free;
      default:           ctrl = '0;
    endcase
  end

  always_comb begin
    case (ch_q)
      2'd0:    sum_sel = red_sum_q;
      2'd1:    sum_sel = green_sum_q;
      default: sum_sel = blue_sum_q;
    endcase
  end

  // Shared divider step: try to take count << bit from the remainder.
  assign dvs      = (SW + 1)'(cnt_q) << bit_q;
  assign trial    = {1'b0, rem_q} - dvs;
  assign ge       = !trial[SW];
  assign quo_next = {quo_q[6:0], ge};

  assign hue_bad  = (avg_q[2] < min_blue_q) || outside_hue(avg_q[0], hue_tol_q)
                    || outside_hue(avg_q[1], hue_tol_q);
  // backward > count / 100 holds exactly when 100 * backward > count.
  assign many_bwd = (BW'(bwd_q) * BW'(nmpc_pkg::PERCENT_DIV)) > BW'(cnt_q);
  assign verdict  = hue_bad  ? nmpc_pkg::VERDICT_HUE :
                    many_bwd ? nmpc_pkg::VERDICT_BACKWARD : nmpc_pkg::VERDICT_NORMAL;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nmpc_pkg::ST_ACC;
      bwd_limit_q <= nmpc_pkg::BACKWARD_LIMIT_RST;
      min_blue_q  <= nmpc_pkg::MIN_AVG_BLUE_RST;
      hue_tol_q   <= nmpc_pkg::HUE_TOL_RST;
      red_sum_q   <= '0;
      green_sum_q <= '0;
      blue_sum_q  <= '0;
      cnt_q       <= '0;
      bwd_q       <= '0;
      bit_q       <= '0;
      ch_q        <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          nmpc_pkg::REG_BACKWARD_LIMIT: bwd_limit_q <= cfg_data_i;
          nmpc_pkg::REG_MIN_AVG_BLUE:   min_blue_q  <= cfg_data_i;
          nmpc_pkg::REG_HUE_TOL:        hue_tol_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (pix_take) begin
        red_sum_q   <= red_sum_q + SW'(s_axis_tdata[7:0]);
        green_sum_q <= green_sum_q + SW'(s_axis_tdata[15:8]);
        blue_sum_q  <= blue_sum_q + SW'(s_axis_tdata[23:16]);
        cnt_q       <= cnt_q + 1'b1;
        if (s_axis_tdata[23:16] < bwd_limit_q) bwd_q <= bwd_q + 1'b1;
      end
      if (ctrl.load_rem) bit_q <= 3'd7;
      else if (ctrl.div_step) bit_q <= bit_q - 3'd1;
      if (ctrl.div_last) ch_q <= ch_q + 2'd1;
      if (ctrl.finish) begin
        red_sum_q   <= '0;
        green_sum_q <= '0;
        blue_sum_q  <= '0;
        cnt_q       <= '0;
        bwd_q       <= '0;
        ch_q        <= '0;
        m_valid_q   <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_rem) begin
      rem_q <= sum_sel;
      quo_q <= '0;
    end else if (ctrl.div_step) begin
      if (ge) rem_q <= trial[SW-1:0];
      quo_q <= quo_next;
    end
    if (ctrl.div_last) avg_q[ch_q] <= quo_next;
    if (ctrl.finish) begin
      m_data_q <= {avg_q[2], avg_q[1], avg_q[0]};
      m_user_q <= verdict;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_PIXELS))
    else $error("pixel count past limit");

  a_bwd_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bwd_q <= cnt_q)
    else $error("backward count exceeds pixel count");

  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after last pixel");

  a_verdict_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("invalid verdict code");

endmodule

`default_nettype wire

/* tb/normal_map_pixel_classifier_unit_tb.sv */
`timescale 1ns / 1ps

module normal_map_pixel_classifier_unit_tb;

  localparam int unsigned LIMIT_CYCLES  = 2000000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_PIXELS = 530;
  // Index 3 maps to no register and must be ignored.
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  typedef enum int unsigned {
    IMG_NOISE,
    IMG_NORMAL
  } image_kind_e;

  typedef struct packed {
    logic [1:0] verdict;
    logic [7:0] avg_red;
    logic [7:0] avg_green;
    logic [7:0] avg_blue;
  } image_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // red [7:0], green [15:8], blue [23:16]
  logic        s_axis_tlast = 1'b0;  // last_pixel
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // average_red, average_green, average_blue
  logic [1:0]  m_axis_tuser;         // verdict
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [7:0]  cfg_data_i = '0;

  // Register copies and image accumulators of the predictor.
  logic [7:0]  shadow_backward_limit = nmpc_pkg::BACKWARD_LIMIT_RST;
  logic [7:0]  shadow_min_blue       = nmpc_pkg::MIN_AVG_BLUE_RST;
  logic [7:0]  shadow_hue_tol        = nmpc_pkg::HUE_TOL_RST;
  int unsigned acc_red, acc_green, acc_blue, acc_count, acc_backward;

  image_result_t expected_results[$];
  image_result_t oldest_result;

  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned images_done = 0;
  int unsigned settings_used = 0;
  int unsigned verdict_tally[3] = '{0, 0, 0};
  int unsigned ready_hold = 0;
  bit          calm = 1'b0;

  normal_map_pixel_classifier_unit #(
    .MAX_PIXELS(nmpc_pkg::MAX_PIXELS_DEF)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("FAIL normal_map_pixel_classifier_unit");
      $finish;
    end
  end

  // Receiver stalls come in bursts of random length, counted by ready_hold.
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      ready_hold <= $urandom_range(0, 18);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH cycle %0d: %s", cycle_count, what);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with no image pending");
      end else begin
        oldest_result = expected_results.pop_front();
        images_done++;
        if (oldest_result.verdict < 3) verdict_tally[oldest_result.verdict]++;
        if (m_axis_tuser !== oldest_result.verdict)
          report_mismatch($sformatf("verdict %0d, want %0d", m_axis_tuser,
                                    oldest_result.verdict));
        if (m_axis_tdata[7:0] !== oldest_result.avg_red)
          report_mismatch($sformatf("average red %0d, want %0d", m_axis_tdata[7:0],
                                    oldest_result.avg_red));
        if (m_axis_tdata[15:8] !== oldest_result.avg_green)
          report_mismatch($sformatf("average green %0d, want %0d", m_axis_tdata[15:8],
                                    oldest_result.avg_green));
        if (m_axis_tdata[23:16] !== oldest_result.avg_blue)
          report_mismatch($sformatf("average blue %0d, want %0d", m_axis_tdata[23:16],
                                    oldest_result.avg_blue));
      end
    end
  end

  function automatic logic [7:0] mean_of(input int unsigned sum);
    if (acc_count == 0) return 8'd0;
    return 8'(sum / acc_count);
  endfunction

  // Bounds are signed, so a tolerance above 128 never rejects on the low side.
  function automatic bit outside_hue(input logic [7:0] avg);
    int a, t;
    a = int'(avg);
    t = int'(shadow_hue_tol);
    return (a < int'(nmpc_pkg::HUE_CENTER) - t) || (a > int'(nmpc_pkg::HUE_CENTER) + t);
  endfunction

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  task automatic classify_pixel(input logic [7:0] r, g, b, input logic last);
    image_result_t res;
    // Pixels past the limit are dropped, but their last mark still counts.
    if (acc_count < nmpc_pkg::MAX_PIXELS_DEF) begin
      acc_red   += r;
      acc_green += g;
      acc_blue  += b;
      acc_count++;
      if (b < shadow_backward_limit) acc_backward++;
    end
    if (last) begin
      res.avg_red   = mean_of(acc_red);
      res.avg_green = mean_of(acc_green);
      res.avg_blue  = mean_of(acc_blue);
      if (res.avg_blue < shadow_min_blue || outside_hue(res.avg_red) ||
          outside_hue(res.avg_green))
        res.verdict = nmpc_pkg::VERDICT_HUE;
      else if (acc_backward > acc_count / nmpc_pkg::PERCENT_DIV)
        res.verdict = nmpc_pkg::VERDICT_BACKWARD;
      else
        res.verdict = nmpc_pkg::VERDICT_NORMAL;
      expected_results.push_back(res);
      acc_red = 0;
      acc_green = 0;
      acc_blue = 0;
      acc_count = 0;
      acc_backward = 0;
    end
  endtask

  task automatic send_pixel(input logic [7:0] r, g, b, input logic last);
    if (!calm && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, g, r};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    classify_pixel(r, g, b, last);
    pixels_sent++;
  endtask

  // Stop sending and let every pending result drain out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      nmpc_pkg::REG_BACKWARD_LIMIT: shadow_backward_limit = val;
      nmpc_pkg::REG_MIN_AVG_BLUE:   shadow_min_blue = val;
      nmpc_pkg::REG_HUE_TOL:        shadow_hue_tol = val;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [7:0] limit, min_blue, tol, input bit stray);
    write_reg(nmpc_pkg::REG_BACKWARD_LIMIT, limit);
    write_reg(nmpc_pkg::REG_MIN_AVG_BLUE, min_blue);
    write_reg(nmpc_pkg::REG_HUE_TOL, tol);
    if (stray) write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_image(input int unsigned n_pixels, input image_kind_e kind,
                            input int unsigned backward_pm);
    int          tol, c_red, c_green, lo;
    int unsigned i;
    logic [7:0]  r, g, b;
    tol = int'(shadow_hue_tol);
    // Per-image hue centers straddle the tolerance bounds.
    c_red   = 128 + int'($urandom_range(0, 2 * tol + 4)) - (tol + 2);
    c_green = 128 + int'($urandom_range(0, 2 * tol + 4)) - (tol + 2);
    lo = int'(shadow_min_blue) - 4;
    if (lo < int'(shadow_backward_limit)) lo = int'(shadow_backward_limit);
    if (lo > 255) lo = 255;
    for (i = 0; i < n_pixels; i++) begin
      if (kind == IMG_NOISE) begin
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
      end else begin
        r = clamp_byte(c_red + int'($urandom_range(0, 8)) - 4);
        g = clamp_byte(c_green + int'($urandom_range(0, 8)) - 4);
        if (shadow_backward_limit != 0 && $urandom_range(0, 999) < backward_pm)
          b = 8'($urandom_range(0, int'(shadow_backward_limit) - 1));
        else
          b = 8'($urandom_range(lo, 255));
      end
      send_pixel(r, g, b, i == n_pixels - 1);
    end
  endtask

  function automatic int unsigned pick_backward_pm();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 20;
      default: return 60;
    endcase
  endfunction

  function automatic logic [7:0] pick_level(input int unsigned hi);
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'(hi);
      default: return 8'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic send_random_image();
    int unsigned n;
    image_kind_e kind;
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(150, 500) : $urandom_range(1, 60);
    kind = ($urandom_range(0, 4) == 0) ? IMG_NOISE : IMG_NORMAL;
    send_image(n, kind, pick_backward_pm());
  endtask

  // Reset values, hue and blue boundaries, and the backward threshold.
  task automatic test_reset_defaults();
    int unsigned k;
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd255, 1'b1);
    send_pixel(8'd68, 8'd128, 8'd255, 1'b1);
    send_pixel(8'd67, 8'd128, 8'd255, 1'b1);
    send_pixel(8'd188, 8'd128, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd189, 8'd255, 1'b1);
    send_pixel(8'd128, 8'd68, 8'd230, 1'b1);
    send_pixel(8'd128, 8'd128, 8'd229, 1'b1);
    // One pixel just below the backward limit in a seven pixel image.
    for (k = 0; k < 6; k++) send_pixel(8'd128, 8'd128, 8'd255, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd89, 1'b1);
    // A blue equal to the limit is not backward.
    for (k = 0; k < 6; k++) send_pixel(8'd128, 8'd128, 8'd255, 1'b0);
    send_pixel(8'd128, 8'd128, 8'd90, 1'b1);
  endtask

  task automatic test_register_extremes();
    logic [7:0]  limits[5]    = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd90};
    logic [7:0]  min_blues[5] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd230};
    logic [7:0]  tols[5]      = '{8'd0, 8'd255, 8'd128, 8'd128, 8'd60};
    int unsigned s, k;
    for (s = 0; s < 5; s++) begin
      wait_drained();
      program_regs(limits[s], min_blues[s], tols[s], s == 0);
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'b1);
      for (k = 0; k < 4; k++) send_random_image();
    end
  endtask

  task automatic test_random_images();
    int unsigned target, phase_start;
    target = pixels_sent + RANDOM_PIXELS;
    phase_start = pixels_sent;
    wait_drained();
    program_regs(pick_level(255), pick_level(255), pick_level(128), 1'b0);
    while (pixels_sent < target) begin
      if (target - pixels_sent < 300) calm = 1'b1;
      if (pixels_sent - phase_start >= 250) begin
        wait_drained();
        program_regs(pick_level(255), pick_level(255),
                     ($urandom_range(0, 7) == 0) ? 8'($urandom_range(129, 255))
                                                 : pick_level(128),
                     $urandom_range(0, 3) == 0);
        phase_start = pixels_sent;
      end
      send_random_image();
    end
  endtask

  initial begin
    acc_red = 0;
    acc_green = 0;
    acc_blue = 0;
    acc_count = 0;
    acc_backward = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_register_extremes();
    test_random_images();

    wait_drained();
    $display("Sent %0d pixels in %0d images over %0d register settings.",
             pixels_sent, images_done, settings_used);
    $display("Verdicts seen: hue %0d, backward %0d, normal map %0d.",
             verdict_tally[0], verdict_tally[1], verdict_tally[2]);
    if (errors == 0) begin
      $display("PASS normal_map_pixel_classifier_unit");
    end else begin
      $display("FAIL normal_map_pixel_classifier_unit");
    end
    $finish;
  end

endmodule
